// ===== hw/rtl/sab_pkg.sv =====
// Shared types and constants for the squared-domain alpha blend pipeline.
package sab_pkg;

  typedef logic [7:0]  pix_t;
  typedef logic [15:0] sq_t;
  typedef logic [31:0] prod_t;
  typedef logic [25:0] mval_t;

  localparam int unsigned NumCh     = 3;
  localparam int unsigned RootSteps = 8;
  localparam int unsigned PreStages = 3;
  localparam int unsigned NumStages = PreStages + RootSteps;

  localparam sq_t        FullScale = 16'd65280;
  localparam logic [8:0] Q8One     = 9'd256;

endpackage

// ===== hw/rtl/sab_root.sv =====
// Pipelined rounded square root, one result bit per stage.
module sab_root (
  input  logic                                clk_i,
  input  logic [sab_pkg::RootSteps-1:0]       en_i,
  input  sab_pkg::mval_t                      m_i,
  output sab_pkg::pix_t                       root_o
);
  import sab_pkg::*;

  mval_t m_q [RootSteps-1];
  pix_t  r_q [RootSteps];

  for (genvar k = 0; k < RootSteps; k++) begin : g_step
    mval_t      m_in;
    pix_t       r_in;
    pix_t       t;
    logic [8:0] odd;
    logic [17:0] odd2;
    mval_t      lhs;
    pix_t       r_d;

    if (k == 0) begin : g_first
      assign m_in = m_i;
      assign r_in = '0;
    end else begin : g_next
      assign m_in = m_q[k-1];
      assign r_in = r_q[k-1];
    end

    // Keep bit if (2t-1)^2 * 255 <= floor(N / 64)
    assign t    = r_in | pix_t'(1 << (RootSteps - 1 - k));
    assign odd  = {t, 1'b0} - 9'd1;
    assign odd2 = 18'(odd) * 18'(odd);
    assign lhs  = {odd2, 8'd0} - {8'd0, odd2};
    assign r_d  = (lhs <= m_in) ? t : r_in;

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        r_q[k] <= r_d;
      end
    end

    if (k < RootSteps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          m_q[k] <= m_in;
        end
      end
    end
  end

  assign root_o = r_q[RootSteps-1];

endmodule

// ===== hw/rtl/squared_domain_alpha_blend.sv =====
// Top level of the squared-domain alpha blend, one pixel per clock unless stalled.
//
//  channel   dir  payload                                          handshake
//  s_axis    in   back_ch0..2, over_ch0..2, over_opacity (56 bit)  tvalid/tready
//  m_axis    out  mix_ch0..2 (24 bit)                              tvalid/tready
//  cfg       in   global_alpha (9 bit)                             cfg_we_i
//
// Stages in order: weight and squares, two products, the sum, then eight square root
// stages, one result bit each. One pixel enters per cycle unless stalled.
// Each stage holds while every stage after it is full and the output stalls;
// bubbles close up, so a stalled output still lets pixels enter.
// Reset clears the stage valid bits and sets global_alpha to 256.
module squared_domain_alpha_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // back_ch0, back_ch1, back_ch2, over_ch0, over_ch1, over_ch2, over_opacity
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mix_ch0, mix_ch1, mix_ch2
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);
  import sab_pkg::*;

  logic [8:0]           ga_q;
  logic [NumStages-1:0] vld_q, vld_d, rdy;

  pix_t        back [NumCh];
  pix_t        over [NumCh];
  pix_t        opacity;
  logic [8:0]  g;
  logic [16:0] w_full;

  sq_t   w_q, wc_q;
  sq_t   osq_q [NumCh];
  sq_t   bsq_q [NumCh];
  prod_t pa_q  [NumCh];
  prod_t pb_q  [NumCh];
  mval_t mv_q  [NumCh];
  pix_t  root  [NumCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ga_q <= Q8One;
    end else if (cfg_we_i) begin
      ga_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    rdy[NumStages-1] = ~vld_q[NumStages-1] | m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  assign vld_d = {vld_q[NumStages-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NumStages-1];

  assign opacity = s_axis_tdata[55:48];
  assign g       = ga_q[8] ? Q8One : ga_q;
  assign w_full  = 17'(opacity) * 17'(g);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      w_q  <= w_full[15:0];
      wc_q <= FullScale - w_full[15:0];
    end
  end

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    prod_t msum;

    assign back[c] = s_axis_tdata[8*c +: 8];
    assign over[c] = s_axis_tdata[8*(c+NumCh) +: 8];
    assign msum    = pa_q[c] + pb_q[c];

    always_ff @(posedge clk_i) begin
      if (rdy[0]) begin
        osq_q[c] <= 16'(over[c]) * 16'(over[c]);
        bsq_q[c] <= 16'(back[c]) * 16'(back[c]);
      end
      if (rdy[1]) begin
        pa_q[c] <= 32'(osq_q[c]) * 32'(w_q);
        pb_q[c] <= 32'(bsq_q[c]) * 32'(wc_q);
      end
      if (rdy[2]) begin
        mv_q[c] <= msum[31:6];
      end
    end

    sab_root u_root (
      .clk_i  (clk_i),
      .en_i   (rdy[NumStages-1:PreStages]),
      .m_i    (mv_q[c]),
      .root_o (root[c])
    );

    assign m_axis_tdata[8*c +: 8] = root[c];
  end

endmodule

// ===== hw/rtl/sab_checker.sv =====
// Port-level checks for the alpha blend top level, attached by bind.
module sab_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  logic [3:0] since_rst_q;
  logic       s_xfer;

  assign s_xfer = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_rst_q <= '0;
    end else if (since_rst_q != 4'd15) begin
      since_rst_q <= since_rst_q + 4'd1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input blocked while output side is free");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    since_rst_q == 4'd15 && $past(s_xfer, 11) &&
    $past(m_axis_tready, 1) && $past(m_axis_tready, 2) && $past(m_axis_tready, 3) &&
    $past(m_axis_tready, 4) && $past(m_axis_tready, 5) && $past(m_axis_tready, 6) &&
    $past(m_axis_tready, 7) && $past(m_axis_tready, 8) && $past(m_axis_tready, 9) &&
    $past(m_axis_tready, 10) |-> m_axis_tvalid)
    else $error("transfer did not arrive after eleven free cycles");

endmodule

bind squared_domain_alpha_blend sab_checker u_sab_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/blend_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts each blended pixel and compares it with the output stream.
module blend_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // back_ch0, back_ch1, back_ch2, over_ch0, over_ch1, over_ch2, over_opacity
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mix_ch0, mix_ch1, mix_ch2
  input  logic [23:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import sab_pkg::*;

  typedef pix_t [NumCh-1:0] mix_t;

  mix_t       expected_mix[$];
  logic [8:0] global_alpha = Q8One;

  function automatic pix_t root_of_blend(pix_t bg, pix_t ov, longint unsigned weight);
    longint unsigned b, o, num4, trial, odd, root;
    b = bg;
    o = ov;
    num4 = 4 * (o * o * weight + b * b * (FullScale - weight));
    root = 0;
    for (int k = 7; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      odd = 2 * trial - 1;
      if (odd * odd * FullScale <= num4) root = trial;
    end
    return pix_t'(root > 255 ? 255 : root);
  endfunction

  function automatic mix_t predict_mix(logic [55:0] pixel, logic [8:0] alpha);
    longint unsigned gain, weight;
    mix_t m;
    gain = (alpha > Q8One) ? Q8One : alpha;
    weight = pixel[55:48] * gain;
    for (int c = 0; c < NumCh; c++) begin
      m[c] = root_of_blend(pixel[8*c +: 8], pixel[24 + 8*c +: 8], weight);
    end
    return m;
  endfunction

  always @(posedge clk_i) begin
    mix_t want, got;
    if (!rst_ni) begin
      global_alpha = Q8One;
      expected_mix.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_mix.size() == 0) begin
          $error("output transfer with no pixel pending: %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_mix.pop_front();
          checked_o++;
          for (int c = 0; c < NumCh; c++) begin
            if (got[c] !== want[c]) begin
              $error("mix_ch%0d: expected %0d, got %0d", c, want[c], got[c]);
              fail_count_o++;
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_mix.insert(expected_mix.size(), predict_mix(s_axis_tdata, global_alpha));
      end
      if (cfg_we_i) global_alpha = cfg_wdata_i;
    end
    pending_o = expected_mix.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top-level testbench: clock, reset, pixel stimulus and verdict for the alpha blend.
module testbench;
  import sab_pkg::*;

  localparam int unsigned NumPhases     = 9;
  localparam int unsigned PhaseItems    = 50;
  localparam int unsigned LatencyCycles = NumStages + 4;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned CycleLimit    = 300000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [8:0]  cfg_wdata_i   = '0;

  int mismatches, pending, checked;
  int cycles       = 0;
  int holds_asked  = 0;
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;

  squared_domain_alpha_blend dut (.*);

  blend_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i,
    .fail_count_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [55:0] pack_pixel(pix_t b0, pix_t b1, pix_t b2,
                                             pix_t o0, pix_t o1, pix_t o2, pix_t op);
    return {op, o2, o1, o0, b2, b1, b0};
  endfunction

  function automatic pix_t random_level();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return pix_t'($urandom_range(0, 255));
  endfunction

  function automatic logic [55:0] random_pixel();
    pix_t op;
    case ($urandom_range(0, 9))
      0:       op = 8'd0;
      1:       op = 8'd255;
      2:       op = pix_t'($urandom_range(1, 3));
      default: op = pix_t'($urandom_range(0, 255));
    endcase
    return pack_pixel(random_level(), random_level(), random_level(),
                      random_level(), random_level(), random_level(), op);
  endfunction

  // Receiver: random stalls, steady stretches, and a long hold on request.
  initial begin : rx_side
    int hold_left;
    int stall_left;
    int holds_served;
    hold_left    = 0;
    stall_left   = 0;
    holds_served = 0;
    forever begin
      @(negedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(logic [55:0] pixel);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pixel;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (pending != 0);
    repeat (LatencyCycles) @(negedge clk_i);
  endtask

  task automatic write_alpha(logic [8:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_directed();
    send_pixel(pack_pixel(0, 0, 0, 0, 0, 0, 0));
    send_pixel(pack_pixel(255, 255, 255, 255, 255, 255, 255));
    send_pixel(pack_pixel(0, 0, 0, 255, 255, 255, 255));
    send_pixel(pack_pixel(255, 255, 255, 0, 0, 0, 255));
    send_pixel(pack_pixel(0, 0, 0, 255, 255, 255, 0));
    send_pixel(pack_pixel(255, 255, 255, 0, 0, 0, 0));
    send_pixel(pack_pixel(0, 0, 0, 255, 255, 255, 128));
    send_pixel(pack_pixel(255, 255, 255, 0, 0, 0, 128));
    send_pixel(pack_pixel(0, 128, 255, 255, 128, 0, 1));
    send_pixel(pack_pixel(0, 128, 255, 255, 128, 0, 254));
    send_pixel(pack_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
    send_pixel(pack_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
    send_pixel(pack_pixel(1, 1, 1, 254, 254, 254, 127));
    send_pixel(pack_pixel(100, 200, 50, 100, 200, 50, 77));
    send_pixel(pack_pixel(10, 20, 30, 240, 230, 220, 64));
    send_pixel(pack_pixel(0, 0, 0, 1, 1, 1, 255));
    send_pixel(pack_pixel(0, 0, 0, 1, 1, 1, 64));
    send_pixel(pack_pixel(254, 1, 127, 1, 254, 128, 192));
  endtask

  initial begin : stimulus
    logic [8:0] plan [NumPhases];
    plan = '{Q8One, 9'd0, 9'd511, 9'd257, 9'd1, 9'd128, 9'd255,
             9'($urandom_range(0, 511)), 9'($urandom_range(257, 511))};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      write_alpha(plan[p]);
      tx_steady = (p == 3 || p == 5);
      rx_steady = (p == 3);
      if (p == 5) holds_asked++;
      if (p == 0) run_directed();
      repeat (PhaseItems) send_pixel(random_pixel());
      s_axis_tvalid <= 1'b0;
    end
    wait_idle();
    $display("Blended %0d pixels under %0d global alpha settings, 0 through 511.",
             checked, NumPhases);
    $display("Output held off %0d cycles once while pixels kept arriving.", HoldCycles);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
